// ----- sv/itpt_pkg.sv -----
// Shared types and constants for the integer-to-text formatter.
// Used by the front classifier, the queue and the back formatter; no dependencies.
package itpt_pkg;

    // Input flag bit positions.
    localparam int FlZeroPad = 0;
    localparam int FlSigned  = 1;
    localparam int FlPlus    = 2;
    localparam int FlSpace   = 3;
    localparam int FlLeft    = 4;
    localparam int FlLower   = 5;

    // Character codes.
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChX     = 8'h78;
    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChLowerA = 8'h61;

    // Valid base range.
    localparam logic [5:0] RadixMin = 6'd2;
    localparam logic [5:0] RadixMax = 6'd36;

    // Queue between front and back.
    localparam int QueueDepth = 2;

    // One classified request, as the front hands it to the back.
    typedef struct packed {
        logic [31:0] mag;        // magnitude to convert
        logic [5:0]  radix;      // base, known to be 2..36
        logic        has_sign;   // a sign character is printed
        logic [7:0]  sign_ch;    // the sign character
        logic [1:0]  pre_len;    // prefix length: 2 for hex, 1 for octal
        logic [6:0]  width;      // field width, signed
        logic [6:0]  prec;       // precision, clamped to 0..MAX_DIGITS
        logic        zero_pad;   // zero padding, already cleared by left align
        logic        left;       // left alignment
        logic        lower;      // lowercase digits
    } t_item;

    // Maps a digit value below 36 to its character.
    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
        logic [7:0] ch;
        if (d < 6'd10) begin
            ch = ChZero + {2'b00, d};
        end else begin
            ch = (lower ? ChLowerA : ChUpperA) + {2'b00, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// ----- sv/itpt_front.sv -----
// Front part of the formatter: accepts requests, drops invalid bases and
// classifies sign, prefix and precision. Depends on itpt_pkg.
module itpt_front #(
    parameter int MAX_DIGITS = 32
) (
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [57:0]       i_s_axis_tdata,
    input  logic              i_q_full,
    output logic              o_q_push,
    output itpt_pkg::t_item   o_q_item
);
    import itpt_pkg::*;

    localparam logic [7:0] MaxDig = 8'(MAX_DIGITS);

    logic [31:0] value;
    logic [5:0]  radix;
    logic [6:0]  text_width;
    logic [6:0]  min_digits;
    logic [5:0]  format_flags;
    logic        radix_ok;
    logic        accept;

    // Unpack the request word.
    assign value        = i_s_axis_tdata[31:0];
    assign radix        = i_s_axis_tdata[37:32];
    assign text_width   = i_s_axis_tdata[44:38];
    assign min_digits   = i_s_axis_tdata[51:45];
    assign format_flags = i_s_axis_tdata[57:52];

    assign radix_ok        = (radix >= RadixMin) && (radix <= RadixMax);
    assign o_s_axis_tready = !i_q_full;
    assign accept          = i_s_axis_tvalid && !i_q_full;
    assign o_q_push        = accept && radix_ok;

    // Classify sign, prefix, padding mode and precision.
    always_comb begin
        o_q_item          = '0;
        o_q_item.radix    = radix;
        o_q_item.width    = text_width;
        o_q_item.left     = format_flags[FlLeft];
        o_q_item.zero_pad = format_flags[FlZeroPad] && !format_flags[FlLeft];
        o_q_item.lower    = format_flags[FlLower];
        o_q_item.mag      = value;
        if (format_flags[FlSigned] && value[31]) begin
            o_q_item.has_sign = 1'b1;
            o_q_item.sign_ch  = ChMinus;
            o_q_item.mag      = 32'd0 - value;
        end else if (format_flags[FlPlus]) begin
            o_q_item.has_sign = 1'b1;
            o_q_item.sign_ch  = ChPlus;
        end else if (format_flags[FlSpace]) begin
            o_q_item.has_sign = 1'b1;
            o_q_item.sign_ch  = ChSpace;
        end
        if (radix == 6'd16) begin
            o_q_item.pre_len = 2'd2;
        end else if (radix == 6'd8) begin
            o_q_item.pre_len = 2'd1;
        end
        if (min_digits[6]) begin
            o_q_item.prec = 7'd0;
        end else if ({1'b0, min_digits} > MaxDig) begin
            o_q_item.prec = MaxDig[6:0];
        end else begin
            o_q_item.prec = min_digits;
        end
    end

endmodule

// ----- sv/itpt_fifo.sv -----
// Short queue of classified requests between the front and the back.
// Depends on itpt_pkg for the entry type and depth.
module itpt_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  itpt_pkg::t_item   i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output itpt_pkg::t_item   o_item
);
    import itpt_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_item            r_mem [QueueDepth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CntW'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/itpt_div.sv -----
// Iterative divider of a 32-bit magnitude by a 6-bit base, eight quotient
// bits per cycle while busy. No dependencies.
module itpt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [5:0]  i_radix,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [5:0]  o_rem
);

    logic [31:0] r_work;
    logic [5:0]  r_rem;
    logic [5:0]  r_radix;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [31:0] n_work;
    logic [5:0]  n_rem;

    // Eight restoring steps on the top byte of the working word.
    always_comb begin
        logic [6:0] trial;
        n_work = r_work;
        n_rem  = r_rem;
        for (int i = 0; i < 8; i++) begin
            trial  = {n_rem, n_work[31]};
            n_work = {n_work[30:0], 1'b0};
            if (trial >= {1'b0, r_radix}) begin
                n_rem     = 6'(trial - {1'b0, r_radix});
                n_work[0] = 1'b1;
            end else begin
                n_rem = trial[5:0];
            end
        end
    end

    // Operand load and step sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work  <= i_dividend;
            r_rem   <= '0;
            r_radix <= i_radix;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;
    assign o_rem  = r_rem;

endmodule

// ----- sv/itpt_back.sv -----
// Back part of the formatter (uses itpt_pkg, itpt_div): extracts digits with the
// divider, lays out the text segments and emits one character per unstalled cycle.
module itpt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  itpt_pkg::t_item   i_q_item,
    output logic              o_q_pop,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,
    output logic              o_m_axis_tlast
);
    import itpt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_SETUP = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state      r_state;
    t_item       r_item;
    logic [5:0]  r_digits [32];
    logic [5:0]  r_nd;
    logic [5:0]  r_pos;
    logic [5:0]  r_len;
    logic [7:0]  r_b1, r_b2, r_b3, r_b5, r_b6;
    logic        r_m_valid;
    logic [7:0]  r_m_char;
    logic        r_m_last;
    logic        r_div_run;

    logic        div_start;
    logic [31:0] div_dividend;
    logic        div_done;
    logic [31:0] div_quot;
    logic [5:0]  div_rem;

    logic [6:0]  prec;
    logic [7:0]  body;
    logic [8:0]  pad;
    logic        pad_pos;
    logic [7:0]  len_full;
    logic [7:0]  lead;
    logic [7:0]  zpad;
    logic [7:0]  b2, b3, b5;
    logic [7:0]  pos8;
    logic [7:0]  dig_idx;
    logic [7:0]  ch;
    logic        out_free;
    logic        last_now;

    itpt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_radix    (r_item.radix),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // The first division takes the magnitude; each later one takes the
    // quotient that the divider has just finished.
    assign o_q_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign div_start    = (r_state == S_DIV) &&
                          ((r_nd == '0 && !div_done && !r_div_run) ||
                           (div_done && div_quot != '0));
    assign div_dividend = div_done ? div_quot : r_item.mag;

    // Tracks whether the first division of an item has been started.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run <= 1'b0;
        end else if (r_state != S_DIV) begin
            r_div_run <= 1'b0;
        end else if (div_start) begin
            r_div_run <= 1'b1;
        end
    end

    // Segment layout from digit count, sign, prefix, width and precision.
    always_comb begin
        prec     = (r_item.prec > {1'b0, r_nd}) ? r_item.prec : {1'b0, r_nd};
        body     = {7'd0, r_item.has_sign} + {6'd0, r_item.pre_len} + {1'b0, prec};
        pad      = {{2{r_item.width[6]}}, r_item.width} - {1'b0, body};
        pad_pos  = !pad[8] && (pad != '0);
        len_full = pad_pos ? {1'b0, r_item.width} : body;
        lead     = (!r_item.zero_pad && !r_item.left && pad_pos) ? pad[7:0] : 8'd0;
        zpad     = (r_item.zero_pad && pad_pos) ? pad[7:0] : 8'd0;
        b2       = lead + {7'd0, r_item.has_sign};
        b3       = b2 + {6'd0, r_item.pre_len};
        b5       = b3 + zpad + {1'b0, prec} - {2'b00, r_nd};
    end

    // Character at the current position.
    always_comb begin
        pos8    = {2'b00, r_pos};
        dig_idx = r_b6 - 8'd1 - pos8;
        if (pos8 < r_b1) begin
            ch = ChSpace;
        end else if (pos8 < r_b2) begin
            ch = r_item.sign_ch;
        end else if (pos8 < r_b3) begin
            ch = (pos8 == r_b2) ? ChZero : ChX;
        end else if (pos8 < r_b5) begin
            ch = ChZero;
        end else if (pos8 < r_b6) begin
            ch = digit_char(r_digits[dig_idx[4:0]], r_item.lower);
        end else begin
            ch = ChSpace;
        end
    end

    assign out_free = !r_m_valid || i_m_axis_tready;
    assign last_now = (r_pos == r_len - 6'd1);

    // Digit buffer, written least significant digit first.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_done) begin
            r_digits[r_nd[4:0]] <= div_rem;
        end
    end

    // Request, layout and output payload registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == S_SETUP) begin
            r_len <= (len_full > 8'd63) ? 6'd63 : len_full[5:0];
            r_b1  <= lead;
            r_b2  <= b2;
            r_b3  <= b3;
            r_b5  <= b5;
            r_b6  <= b5 + {2'b00, r_nd};
        end
        if (r_state == S_EMIT && out_free) begin
            r_m_char <= ch;
            r_m_last <= last_now;
        end
    end

    // Control sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_nd      <= '0;
            r_pos     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // A new character sets valid; a taken one clears it.
            if (r_state == S_EMIT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_nd    <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_nd <= r_nd + 6'd1;
                        if (div_quot == '0) begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_pos   <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_pos <= r_pos + 6'd1;
                        if (last_now) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_char;
    assign o_m_axis_tlast  = r_m_last;

endmodule

// ----- sv/integer_to_padded_text_unit.sv -----
// Flow: the back takes a request from the queue once it is accepted, then runs
// one division per digit (four divider steps and one restart per digit) and the
// S_SETUP layout state; the characters then follow at one per cycle while the
// output is ready, up to 63.
// Capacity: one number at a time in the back; two more wait in the queue.
// Reset: synchronous, active low; clears the queue, sequencer and output valid.
module integer_to_padded_text_unit #(
    parameter int MAX_DIGITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata, low bit up: value[31:0], radix[37:32], text_width[44:38],
    // min_digits[51:45], format_flags[57:52], zero fill[63:58]
    input  logic [63:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata, low bit up: text_char[7:0]
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast
);
    import itpt_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    t_item q_in;
    t_item q_out;

    itpt_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata[57:0]),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_item        (q_in)
    );

    itpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out)
    );

    itpt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_item        (q_out),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
